// ===== design/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_pkg: shared types and constants of the ready-list scheduler
// Request codes, slot status codes, stream widths, output field offsets and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prs_pkg;

    // Request kinds carried in the slave-side tuser
    localparam logic CMD_ACTIVATE  = 1'b0;
    localparam logic CMD_TERMINATE = 1'b1;

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Slave-side tdata layout
    localparam int IN_PRI_LO  = 0;
    localparam int IN_TAIL    = 8;

    // Master-side tdata layout
    localparam int OUT_NEW_LO    = 0;
    localparam int OUT_ERR       = 4;
    localparam int OUT_RUN_VALID = 5;
    localparam int OUT_RUN_LO    = 6;
    localparam int OUT_STARTED   = 10;
    localparam int OUT_FIRST     = 11;

    // Per-slot status
    typedef enum logic [1:0] {
        ST_UNUSED  = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_DONE    = 2'd3
    } t_slot_status;

    // Strobes from the controller to the datapath
    typedef struct packed {
        logic capture;       // take a new request
        logic set_err;       // activate refused, table full
        logic alloc_init;    // take free slot, start insertion walk
        logic ins_advance;   // step insertion walk
        logic ins_write;     // write the new slot entry
        logic link_write;    // hook the new slot after its predecessor
        logic term_init;     // point the walk at the running slot
        logic term_write;    // mark the running slot done
        logic disp_init;     // start dispatch walk at the list head
        logic disp_advance;  // step dispatch walk
        logic disp_start;    // start the current slot
        logic load_out;      // load the result register
    } t_dp_cmd;

    // Flags from the datapath to the controller
    typedef struct packed {
        logic cmd_term;      // captured request is a terminate
        logic full;          // free list empty
        logic walk_go;       // current slot valid and walk bound not reached
        logic ins_adv;       // insertion walk passes the current slot
        logic st_running;    // current slot is running
        logic st_ready;      // current slot is ready
        logic run_valid;     // some task is running
        logic out_free;      // result register can take a new result
    } t_dp_status;

endpackage

// ===== design/priority_ready_list_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_ready_list_scheduler: priority-ordered ready-list task scheduler
// Sequence: an accepted activate runs the insertion walk, a terminate of a
// running task the termination write, then the dispatch walk runs, one table
// read per slot visited, before the result is registered. The next request is
// taken once the result is registered, while that result may still wait.
// Reset: synchronous, active low; free list full, ready list empty, no task
// running; no clearing pass, requests are taken as soon as reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_ready_list_scheduler #(
    parameter int TASK_SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // tdata: priority_req[7:0], tail_mode[8], zero[15:9]
    input  logic [prs_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: command[0]
    input  logic                          i_s_tuser,
    // master side
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // tdata: new_slot[3:0], error_full[4], running_valid[5],
    //        running_slot[9:6], started_now[10], first_run[11], zero[15:12]
    output logic [prs_pkg::M_TDATA_W-1:0] o_m_tdata
);

    prs_pkg::t_dp_cmd    w_cmd;
    prs_pkg::t_dp_status w_status;

    // Sequencer
    prs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Slot table and list state
    prs_dp #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ===== design/prs_ram.sv =====
// ----------------------------------------------------------------------------
// prs_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/prs_ctrl.sv =====
// ----------------------------------------------------------------------------
// prs_ctrl: sequencing controller of the ready-list scheduler
// Steps each request through allocation, insertion walk, termination,
// dispatch walk and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  prs_pkg::t_dp_status  i_status,
    output prs_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE       = 9'b000000001,
        S_DECODE     = 9'b000000010,
        S_INS_WALK   = 9'b000000100,
        S_INS_WRITE  = 9'b000001000,
        S_INS_LINK   = 9'b000010000,
        S_TERM_WRITE = 9'b000100000,
        S_DISP_START = 9'b001000000,
        S_DISP_WALK  = 9'b010000000,
        S_FINISH     = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == S_IDLE);

    // Next state and command strobes
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_status.cmd_term) begin
                    if (i_status.full) begin
                        o_cmd.set_err = 1'b1;
                        n_state       = S_DISP_START;
                    end else begin
                        o_cmd.alloc_init = 1'b1;
                        n_state          = S_INS_WALK;
                    end
                end else if (i_status.run_valid) begin
                    o_cmd.term_init = 1'b1;
                    n_state         = S_TERM_WRITE;
                end else begin
                    n_state = S_DISP_START;
                end
            end
            S_INS_WALK: begin
                if (i_status.walk_go && i_status.ins_adv) begin
                    o_cmd.ins_advance = 1'b1;
                end else begin
                    n_state = S_INS_WRITE;
                end
            end
            S_INS_WRITE: begin
                o_cmd.ins_write = 1'b1;
                n_state         = S_INS_LINK;
            end
            S_INS_LINK: begin
                o_cmd.link_write = 1'b1;
                n_state          = S_DISP_START;
            end
            S_TERM_WRITE: begin
                o_cmd.term_write = 1'b1;
                n_state          = S_DISP_START;
            end
            S_DISP_START: begin
                o_cmd.disp_init = 1'b1;
                n_state         = S_DISP_WALK;
            end
            S_DISP_WALK: begin
                // stop at a running task, start the first ready one
                if (!i_status.walk_go || i_status.st_running) begin
                    n_state = S_FINISH;
                end else if (i_status.st_ready && !i_status.run_valid) begin
                    o_cmd.disp_start = 1'b1;
                    n_state          = S_FINISH;
                end else begin
                    o_cmd.disp_advance = 1'b1;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/prs_dp.sv =====
// ----------------------------------------------------------------------------
// prs_dp: datapath of the ready-list scheduler
// Slot table in RAM (priority, status, started flag, link), list heads,
// walk pointers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prs_dp #(
    parameter int TASK_SLOTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  prs_pkg::t_dp_cmd                 i_cmd,
    output prs_pkg::t_dp_status              o_status,
    input  logic [prs_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [prs_pkg::M_TDATA_W-1:0]    o_m_tdata
);

    localparam int SW          = $clog2(TASK_SLOTS);
    localparam int LW          = $clog2(TASK_SLOTS + 1);
    localparam int STARTED_BIT = LW;
    localparam int STATUS_LO   = LW + 1;
    localparam int PRIO_LO     = LW + 3;
    localparam int W           = LW + 11;
    localparam logic [LW-1:0] END_MARK = LW'(TASK_SLOTS);

    // Control registers
    logic [LW-1:0] r_free_cnt;
    logic [LW-1:0] r_ready_head;
    logic [LW-1:0] r_running;
    logic          r_out_valid;

    // Payload registers
    logic                       r_command;
    logic [7:0]                 r_pri;
    logic                       r_tail;
    logic                       r_err;
    logic                       r_new_ok;
    logic                       r_started;
    logic                       r_first;
    logic [SW-1:0]              r_slot;
    logic [LW-1:0]              r_cur;
    logic [LW-1:0]              r_prev;
    logic [W-1:0]               r_prev_word;
    logic [LW-1:0]              r_steps;
    logic                       r_phase2;
    logic [prs_pkg::M_TDATA_W-1:0] r_out_data;

    logic                   w_full;
    logic [LW-1:0]          n_cur;
    logic [SW-1:0]          w_rd_addr;
    logic [W-1:0]           w_rd_data;
    logic                   w_wr_en;
    logic [SW-1:0]          w_wr_addr;
    logic [W-1:0]           w_wr_data;
    logic [LW-1:0]          w_rd_link;
    logic                   w_rd_started;
    prs_pkg::t_slot_status  w_rd_status;
    logic [7:0]             w_rd_prio;
    logic                   w_prev_valid;
    logic                   w_run_valid;
    logic [LW-1:0]          w_slot_ext;
    logic [SW+3:0]          w_slot_wide;
    logic [LW+3:0]          w_run_wide;
    logic [3:0]             w_new4;
    logic [3:0]             w_run4;
    logic [prs_pkg::M_TDATA_W-1:0] w_out_data;

    // free-list flag: table full once the fill count reaches the end marker
    assign w_full = (r_free_cnt == END_MARK);

    // Slot table
    prs_ram #(
        .WIDTH (W),
        .DEPTH (TASK_SLOTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Unpack the entry read for the current slot
    assign w_rd_link    = w_rd_data[LW-1:0];
    assign w_rd_started = w_rd_data[STARTED_BIT];
    assign w_rd_status  = prs_pkg::t_slot_status'(w_rd_data[STATUS_LO +: 2]);
    assign w_rd_prio    = w_rd_data[PRIO_LO +: 8];

    assign w_prev_valid = (r_prev < END_MARK);
    assign w_run_valid  = (r_running < END_MARK);
    assign w_slot_ext   = LW'(r_slot);

    // Next walk pointer; the read address follows it so data lines up
    always_comb begin
        n_cur = r_cur;
        if (i_cmd.alloc_init || i_cmd.disp_init) begin
            n_cur = r_ready_head;
        end else if (i_cmd.term_init) begin
            n_cur = r_running;
        end else if (i_cmd.ins_advance || i_cmd.disp_advance) begin
            n_cur = w_rd_link;
        end
        w_rd_addr = (n_cur < END_MARK) ? n_cur[SW-1:0] : '0;
    end

    // Table write port
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_cur[SW-1:0];
        w_wr_data = w_rd_data;
        if (i_cmd.ins_write) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_slot;
            w_wr_data = {r_pri, prs_pkg::ST_READY, 1'b0, r_cur};
        end else if (i_cmd.link_write && w_prev_valid) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_prev[SW-1:0];
            w_wr_data = {r_prev_word[W-1:LW], w_slot_ext};
        end else if (i_cmd.term_write) begin
            w_wr_en   = 1'b1;
            w_wr_data = {w_rd_prio, prs_pkg::ST_DONE, w_rd_started, w_rd_link};
        end else if (i_cmd.disp_start) begin
            w_wr_en   = 1'b1;
            w_wr_data = {w_rd_prio, prs_pkg::ST_RUNNING, 1'b1, w_rd_link};
        end
    end

    // Status to the controller
    always_comb begin
        o_status            = '0;
        o_status.cmd_term   = (r_command == prs_pkg::CMD_TERMINATE);
        o_status.full       = w_full;
        o_status.walk_go    = (r_cur < END_MARK) && (r_steps < END_MARK);
        // pass higher priorities first, then equal ones when appending
        o_status.ins_adv    = ((w_rd_prio > r_pri) && !r_phase2)
                              || (r_tail && (w_rd_prio == r_pri));
        o_status.st_running = (w_rd_status == prs_pkg::ST_RUNNING);
        o_status.st_ready   = (w_rd_status == prs_pkg::ST_READY);
        o_status.run_valid  = w_run_valid;
        o_status.out_free   = !r_out_valid || i_m_tready;
    end

    // Result fields, slot numbers cut to their low four bits
    assign w_slot_wide = (SW + 4)'(r_slot);
    assign w_run_wide  = (LW + 4)'(r_running);
    assign w_new4      = r_new_ok ? w_slot_wide[3:0] : 4'd0;
    assign w_run4      = w_run_valid ? w_run_wide[3:0] : 4'd0;

    // Pack the result word
    always_comb begin
        w_out_data                            = '0;
        w_out_data[prs_pkg::OUT_NEW_LO +: 4]  = w_new4;
        w_out_data[prs_pkg::OUT_ERR]          = r_err;
        w_out_data[prs_pkg::OUT_RUN_VALID]    = w_run_valid;
        w_out_data[prs_pkg::OUT_RUN_LO +: 4]  = w_run4;
        w_out_data[prs_pkg::OUT_STARTED]      = r_started;
        w_out_data[prs_pkg::OUT_FIRST]        = r_first;
    end

    // List heads, running slot and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_cnt   <= '0;
            r_ready_head <= END_MARK;
            r_running    <= END_MARK;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.alloc_init) begin
                r_free_cnt <= r_free_cnt + LW'(1);
            end
            if (i_cmd.link_write && !w_prev_valid) begin
                r_ready_head <= w_slot_ext;
            end
            if (i_cmd.term_write) begin
                r_running <= END_MARK;
            end else if (i_cmd.disp_start) begin
                r_running <= r_cur;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request fields, walk state and result data
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (i_cmd.capture) begin
            r_command <= i_s_tuser;
            r_pri     <= i_s_tdata[prs_pkg::IN_PRI_LO +: 8];
            r_tail    <= i_s_tdata[prs_pkg::IN_TAIL];
            r_err     <= 1'b0;
            r_new_ok  <= 1'b0;
            r_started <= 1'b0;
            r_first   <= 1'b0;
        end
        if (i_cmd.set_err) begin
            r_err <= 1'b1;
        end
        if (i_cmd.alloc_init) begin
            r_slot   <= r_free_cnt[SW-1:0];
            r_new_ok <= 1'b1;
            r_prev   <= END_MARK;
            r_steps  <= '0;
            r_phase2 <= 1'b0;
        end
        if (i_cmd.ins_advance) begin
            r_prev      <= r_cur;
            r_prev_word <= w_rd_data;
            r_steps     <= r_steps + LW'(1);
            r_phase2    <= r_phase2 | (w_rd_prio == r_pri);
        end
        if (i_cmd.disp_init) begin
            r_steps <= '0;
        end
        if (i_cmd.disp_advance) begin
            r_steps <= r_steps + LW'(1);
        end
        if (i_cmd.disp_start) begin
            r_started <= 1'b1;
            r_first   <= !w_rd_started;
        end
        if (i_cmd.load_out) begin
            r_out_data <= w_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== design/prs_checker.sv =====
// ----------------------------------------------------------------------------
// prs_checker: port-level checks of the ready-list scheduler
// Watches the stream ports for hand-off rules and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [prs_pkg::S_TDATA_W-1:0] i_s_tdata,
    input logic                          i_s_tuser,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [prs_pkg::M_TDATA_W-1:0] o_m_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed or dropped while stalled");

    // One request at a time: no second request straight after one is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while previous one still in work");

    // A started task is the running one, and first run only on a start
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((!o_m_tdata[prs_pkg::OUT_FIRST]
                          || o_m_tdata[prs_pkg::OUT_STARTED])
                        && (!o_m_tdata[prs_pkg::OUT_STARTED]
                          || o_m_tdata[prs_pkg::OUT_RUN_VALID])))
        else $error("start flags inconsistent with running state");

    // Idle processor reports slot zero; refused activate reports slot zero
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[prs_pkg::OUT_RUN_VALID]
                          || (o_m_tdata[prs_pkg::OUT_RUN_LO +: 4] == 4'd0))
                        && (!o_m_tdata[prs_pkg::OUT_ERR]
                          || (o_m_tdata[prs_pkg::OUT_NEW_LO +: 4] == 4'd0))))
        else $error("slot field not cleared");

endmodule

bind priority_ready_list_scheduler prs_checker u_prs_checker (.*);

// ===== tb/sv/priority_ready_list_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// priority_ready_list_scheduler_tb: self-checking bench for the scheduler
// Drives activate and terminate requests into the slave-side stream. A
// scoreboard class tracks the slot table, free list, ready list and running
// task, and predicts each dispatch outcome. Every result on the master side is
// checked field by field against the oldest prediction. Both stream sides
// idle and stall at random, in phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_ready_list_scheduler_tb;

    localparam int SLOTS          = 16;
    localparam int END_MARK       = SLOTS;
    localparam int WALK_LATENCY   = 2 * SLOTS + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int PHASE_ITEMS    = 400;

    // Fields of one predicted result
    typedef struct packed {
        logic [3:0] new_slot;
        logic       error_full;
        logic       running_valid;
        logic [3:0] running_slot;
        logic       started_now;
        logic       first_run;
    } t_outcome;

    // Slot table tracker and result checker
    class ready_list_board;
        logic [7:0]            slot_pri   [SLOTS];
        prs_pkg::t_slot_status slot_state [SLOTS];
        logic [4:0]            slot_next  [SLOTS];
        logic                  slot_begun [SLOTS];
        logic [4:0]            free_head;
        logic [4:0]            ready_head;
        logic [4:0]            running;
        t_outcome              dispatch_outcomes[$];
        int                    mismatch_count;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                slot_pri[i]   = '0;
                slot_state[i] = prs_pkg::ST_UNUSED;
                slot_next[i]  = 5'(i + 1);
                slot_begun[i] = 1'b0;
            end
            free_head      = '0;
            ready_head     = 5'(END_MARK);
            running        = 5'(END_MARK);
            mismatch_count = 0;
        endfunction

        function int outstanding();
            return dispatch_outcomes.size();
        endfunction

        // Apply one accepted request and queue the outcome it causes
        function void note_request(input logic cmd, input logic [7:0] pri,
                                   input logic tail);
            t_outcome   res;
            logic [4:0] slot;
            logic [4:0] cur;
            logic [4:0] prev;
            int         steps;
            logic       walking;

            res = '0;
            if (cmd == prs_pkg::CMD_ACTIVATE) begin
                if (free_head >= SLOTS) begin
                    res.error_full = 1'b1;
                end else begin
                    slot            = free_head;
                    free_head       = slot_next[slot];
                    slot_pri[slot]  = pri;
                    slot_begun[slot] = 1'b0;
                    // find the insertion point by priority
                    cur   = ready_head;
                    prev  = 5'(END_MARK);
                    steps = 0;
                    while (cur < SLOTS && slot_pri[cur] > pri && steps < SLOTS) begin
                        prev = cur;
                        cur  = slot_next[cur];
                        steps++;
                    end
                    if (tail) begin
                        while (cur < SLOTS && slot_pri[cur] == pri && steps < SLOTS) begin
                            prev = cur;
                            cur  = slot_next[cur];
                            steps++;
                        end
                    end
                    slot_next[slot] = (cur < SLOTS) ? cur : 5'(END_MARK);
                    if (prev < SLOTS) begin
                        slot_next[prev] = slot;
                    end else begin
                        ready_head = slot;
                    end
                    slot_state[slot] = prs_pkg::ST_READY;
                    res.new_slot     = slot[3:0];
                end
            end else if (running < SLOTS) begin
                slot_state[running] = prs_pkg::ST_DONE;
                running             = 5'(END_MARK);
            end

            // dispatch: stop at a running task, else start the first ready one
            cur     = ready_head;
            steps   = 0;
            walking = 1'b1;
            while (walking && cur < SLOTS && steps < SLOTS) begin
                if (slot_state[cur] == prs_pkg::ST_RUNNING) begin
                    walking = 1'b0;
                end else if (slot_state[cur] == prs_pkg::ST_READY && running >= SLOTS) begin
                    running          = cur;
                    slot_state[cur]  = prs_pkg::ST_RUNNING;
                    res.started_now  = 1'b1;
                    res.first_run    = !slot_begun[cur];
                    slot_begun[cur]  = 1'b1;
                    walking          = 1'b0;
                end else begin
                    cur = slot_next[cur];
                    steps++;
                end
            end

            res.running_valid = (running < SLOTS);
            res.running_slot  = (running < SLOTS) ? running[3:0] : 4'd0;
            dispatch_outcomes.push_back(res);
        endfunction

        function void compare_field(input string name, input int want, input int got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatch_count++;
            end
        endfunction

        // Check one accepted result against the oldest prediction
        function void check_outcome(input logic [prs_pkg::M_TDATA_W-1:0] data);
            t_outcome want;

            if (dispatch_outcomes.size() == 0) begin
                $error("result accepted with no request outstanding: %h", data);
                mismatch_count++;
            end else begin
                want = dispatch_outcomes.pop_front();
                compare_field("new_slot", want.new_slot,
                              data[prs_pkg::OUT_NEW_LO +: 4]);
                compare_field("error_full", want.error_full, data[prs_pkg::OUT_ERR]);
                compare_field("running_valid", want.running_valid,
                              data[prs_pkg::OUT_RUN_VALID]);
                compare_field("running_slot", want.running_slot,
                              data[prs_pkg::OUT_RUN_LO +: 4]);
                compare_field("started_now", want.started_now,
                              data[prs_pkg::OUT_STARTED]);
                compare_field("first_run", want.first_run, data[prs_pkg::OUT_FIRST]);
                compare_field("padding", 0,
                              data[prs_pkg::M_TDATA_W-1:prs_pkg::OUT_FIRST+1]);
            end
        endfunction
    endclass

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [prs_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          s_tuser  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [prs_pkg::M_TDATA_W-1:0] m_tdata;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_request   = 1'b0;

    ready_list_board board = new();

    priority_ready_list_scheduler #(
        .TASK_SLOTS (SLOTS)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    // Clock
    initial begin
        forever #2 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off on demand
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Observe handshakes on both sides
    always @(posedge clk) begin
        if (rst_n && s_tvalid && s_tready) begin
            board.note_request(s_tuser, s_tdata[prs_pkg::IN_PRI_LO +: 8],
                               s_tdata[prs_pkg::IN_TAIL]);
        end
        if (rst_n && m_tvalid && m_tready) begin
            board.check_outcome(m_tdata);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    // Offer one request and hold it until accepted
    task automatic send_request(input logic cmd, input logic [7:0] pri, input logic tail);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(prs_pkg::S_TDATA_W-prs_pkg::IN_TAIL-1){1'b0}}, tail, pri};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic wait_all_results();
        while (board.outstanding() != 0) @(posedge clk);
    endtask

    task automatic random_requests(input int count);
        for (int n = 0; n < count; n++) begin
            send_request(1'($urandom_range(1)), 8'($urandom_range(255)),
                         1'($urandom_range(1)));
        end
    endtask

    // Stimulus
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // terminate with nothing running
        send_request(prs_pkg::CMD_TERMINATE, 8'hFF, 1'b1);
        // first task starts at once; the later ones stay ready while it runs
        send_request(prs_pkg::CMD_ACTIVATE, 8'h00, 1'b0);
        send_request(prs_pkg::CMD_ACTIVATE, 8'hFF, 1'b1);
        send_request(prs_pkg::CMD_ACTIVATE, 8'hFF, 1'b0);
        send_request(prs_pkg::CMD_ACTIVATE, 8'hFF, 1'b1);
        send_request(prs_pkg::CMD_ACTIVATE, 8'h00, 1'b1);
        send_request(prs_pkg::CMD_ACTIVATE, 8'h00, 1'b0);
        send_request(prs_pkg::CMD_ACTIVATE, 8'hAA, 1'b0);
        send_request(prs_pkg::CMD_ACTIVATE, 8'h55, 1'b1);
        // retire the running task, then the one dispatched after it
        send_request(prs_pkg::CMD_TERMINATE, 8'h00, 1'b0);
        send_request(prs_pkg::CMD_TERMINATE, 8'h5A, 1'b1);
        send_request(prs_pkg::CMD_ACTIVATE, 8'h80, 1'b1);
        // fill the table with a few shared priority levels
        for (int k = 0; k < 7; k++) begin
            send_request(prs_pkg::CMD_ACTIVATE, 8'($urandom_range(4) * 64),
                         1'($urandom_range(1)));
        end
        // table full
        send_request(prs_pkg::CMD_ACTIVATE, 8'h7F, 1'b1);
        send_request(prs_pkg::CMD_TERMINATE, 8'h01, 1'b0);

        // no idling, then pause until the block drains
        random_requests(PHASE_ITEMS);
        s_tvalid <= 1'b0;
        wait_all_results();

        // sender idles
        send_idle_pct = 53;
        random_requests(PHASE_ITEMS);

        // receiver stalls, opening with a long hold-off so the block backs up
        send_idle_pct  = 0;
        recv_stall_pct = 53;
        hold_request   = 1'b1;
        random_requests(PHASE_ITEMS);

        // both sides idle now and then
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        random_requests(PHASE_ITEMS);

        // drain
        s_tvalid       <= 1'b0;
        recv_stall_pct = 0;
        wait_all_results();
        repeat (WALK_LATENCY) @(posedge clk);

        if (board.mismatch_count == 0 && board.outstanding() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
